FILE: rtl/core/dbem_pkg.sv
// ----------------------------------------------------------------------------
// dbem_pkg
// Shared types and constants of the depth border erosion mask.
// ----------------------------------------------------------------------------
`default_nettype none

package dbem_pkg;

  localparam int WINDOW_DEF    = 11;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;

  localparam int POS_W   = 10;  // output row/column field width
  localparam int SIZE_W  = 11;  // frame_width / frame_height register width
  localparam int BORDER_W = 8;

  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST = 11'd480;
  localparam logic [BORDER_W-1:0] BORDER_WIDTH_RST = 8'd30;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BORDER_WIDTH = 2'd2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_LW    = 3;
  localparam logic [OQ_LW-1:0] OQ_LIMIT = 3'd3;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic        depth_missing;
    logic        frame_start;
  } in_pix_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             keep_point;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/dbem_colmem.sv
// ----------------------------------------------------------------------------
// dbem_colmem
// Per-column vertical run store: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbem_colmem #(
  parameter int DEPTH = dbem_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(dbem_pkg::MAX_WIDTH_DEF),
  parameter int DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on the same address; caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dbem_oq.sv
// ----------------------------------------------------------------------------
// dbem_oq
// Small output queue that decouples the result channel from the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module dbem_oq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire dbem_pkg::out_item_t         push_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dbem_pkg::out_item_t              out_data,
  output logic [dbem_pkg::OQ_LW-1:0]       level
);

  dbem_pkg::out_item_t          q_r [dbem_pkg::OQ_DEPTH];
  logic [dbem_pkg::OQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dbem_pkg::OQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dbem_pkg::OQ_LW-1:0]   level_r, level_nxt;
  logic                         pop;

  assign out_valid = (level_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign level     = level_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r + dbem_pkg::OQ_LW'(push) - dbem_pkg::OQ_LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/depth_border_erosion_mask.sv
// ----------------------------------------------------------------------------
// depth_border_erosion_mask
// Rectangular binary erosion of the depth-valid map with an edge band.
// ----------------------------------------------------------------------------
// One pixel is taken per clock, unless in_stall holds it, in raster order; a
// pixel is valid when present, nonzero and outside the border band. For each
// pixel (r,c) with r and c at least WINDOW-1, one keep flag for
// (r-(WINDOW-1)/2, c-(WINDOW-1)/2) leaves through the stage 1 registers and an
// output queue that holds up to three results. The pace is set by the column
// run memory: one read at input transfer and one write in the next cycle, so
// the sustained rate is one pixel per clock while the result side keeps up.
// No clearing pass is needed after reset.
`default_nettype none

module depth_border_erosion_mask #(
  parameter int WINDOW    = dbem_pkg::WINDOW_DEF,
  parameter int MAX_WIDTH = dbem_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire dbem_pkg::in_pix_t               in_data,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dbem_pkg::out_item_t                  out_data,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dbem_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [dbem_pkg::PDATA_W-1:0]    pwdata,
  output logic      [dbem_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = (CW + 1 > dbem_pkg::SIZE_W) ? CW + 1 : dbem_pkg::SIZE_W;
  localparam int OW   = (CW > dbem_pkg::POS_W) ? CW : dbem_pkg::POS_W;
  localparam int RW   = $clog2(WINDOW + 1);
  localparam int HALF = (WINDOW - 1) / 2;
  localparam int PW   = dbem_pkg::POS_W;
  localparam int HW   = dbem_pkg::SIZE_W;

  localparam logic [RW-1:0] RUN_MAX = RW'(WINDOW);

  // ---------------- configuration ----------------
  logic [HW-1:0]                 frame_width_r, frame_height_r;
  logic [dbem_pkg::BORDER_W-1:0] border_width_r;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= dbem_pkg::FRAME_WIDTH_RST;
      frame_height_r <= dbem_pkg::FRAME_HEIGHT_RST;
      border_width_r <= dbem_pkg::BORDER_WIDTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dbem_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[HW-1:0];
        dbem_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[HW-1:0];
        dbem_pkg::REG_BORDER_WIDTH: border_width_r <= pwdata[dbem_pkg::BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dbem_pkg::REG_FRAME_WIDTH:  prdata = dbem_pkg::PDATA_W'(frame_width_r);
      dbem_pkg::REG_FRAME_HEIGHT: prdata = dbem_pkg::PDATA_W'(frame_height_r);
      dbem_pkg::REG_BORDER_WIDTH: prdata = dbem_pkg::PDATA_W'(border_width_r);
      default:                    prdata = '0;
    endcase
  end

  // clamped frame size
  logic [SW-1:0] w_raw, w_cl;
  logic [HW-1:0] h_cl;

  always_comb begin
    w_raw = SW'(frame_width_r);
    if (w_raw == '0)                  w_cl = SW'(1);
    else if (w_raw > SW'(MAX_WIDTH))  w_cl = SW'(MAX_WIDTH);
    else                              w_cl = w_raw;
    if (frame_height_r == '0)                          h_cl = HW'(1);
    else if (frame_height_r > HW'(dbem_pkg::MAX_HEIGHT)) h_cl = HW'(dbem_pkg::MAX_HEIGHT);
    else                                               h_cl = frame_height_r;
  end

  // ---------------- stage 0: position, classify, memory read ----------------
  logic [PW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [PW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic [SW-1:0] c_ext, c_inc;
  logic [OW-1:0] c_wide;
  logic          pix_ok, emit, acc;
  logic [OW-1:0] c_ofs;

  assign acc = in_valid && !in_stall;

  always_comb begin
    r_cur  = in_data.frame_start ? '0 : row_r;
    c_cur  = in_data.frame_start ? '0 : col_r;
    c_ext  = SW'(c_cur);
    c_inc  = c_ext + SW'(1);
    pix_ok = !in_data.depth_missing && (in_data.depth_mm != '0)
             && (r_cur >= PW'(border_width_r))
             && ((HW'(r_cur) + HW'(border_width_r)) < h_cl)
             && (c_ext >= SW'(border_width_r))
             && ((c_ext + SW'(border_width_r)) < w_cl);
    emit   = (r_cur >= PW'(WINDOW - 1)) && (c_cur >= CW'(WINDOW - 1));
    c_wide = OW'(c_cur);
    c_ofs  = c_wide - OW'(HALF);
    if (c_inc >= w_cl) begin
      col_nxt = '0;
      row_nxt = ((HW'(r_cur) + HW'(1)) >= h_cl) ? '0 : r_cur + PW'(1);
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------- stage 1: run update, memory write ----------------
  logic          s1_valid_r;
  logic [CW-1:0] s1_c_r;
  logic          s1_ok_r, s1_first_r, s1_emit_r, s1_fwd_r;
  logic [RW-1:0] s1_fwd_data_r;
  logic [PW-1:0] s1_row_r, s1_col_r;
  logic [RW-1:0] rd_data, run_base, colrun, rrun_r, rrun_nxt, rr_base;
  logic          push;
  dbem_pkg::out_item_t push_data;

  // an item reading the column that stage 1 writes at the same edge
  // takes the new run value instead of the stale memory word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_c_r        <= c_cur;
      s1_ok_r       <= pix_ok;
      s1_first_r    <= (r_cur == '0);
      s1_emit_r     <= emit;
      s1_fwd_r      <= s1_valid_r && (s1_c_r == c_cur);
      s1_fwd_data_r <= colrun;
      s1_row_r      <= r_cur - PW'(HALF);
      s1_col_r      <= c_ofs[PW-1:0];
    end
  end

  always_comb begin
    run_base = s1_fwd_r ? s1_fwd_data_r : rd_data;
    if (!s1_ok_r)                colrun = '0;
    else if (s1_first_r)         colrun = RW'(1);
    else if (run_base >= RUN_MAX) colrun = RUN_MAX;
    else                         colrun = run_base + RW'(1);
    rr_base = (s1_c_r == '0) ? '0 : rrun_r;
    if (colrun >= RUN_MAX) begin
      rrun_nxt = (rr_base >= RUN_MAX) ? RUN_MAX : rr_base + RW'(1);
    end else begin
      rrun_nxt = '0;
    end
    push                 = s1_valid_r && s1_emit_r;
    push_data.out_row    = s1_row_r;
    push_data.out_col    = s1_col_r;
    push_data.keep_point = (rrun_nxt >= RUN_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rrun_r <= '0;
    end else if (s1_valid_r) begin
      rrun_r <= rrun_nxt;
    end
  end

  dbem_colmem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (RW)
  ) u_colmem (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (c_cur),
    .rd_data (rd_data),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_c_r),
    .wr_data (colrun)
  );

  // ---------------- output queue ----------------
  logic [dbem_pkg::OQ_LW-1:0] oq_level;

  dbem_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (oq_level)
  );

  // room for the item in stage 1 and for the one taken now
  assign in_stall = (oq_level + dbem_pkg::OQ_LW'(push)) >= dbem_pkg::OQ_LIMIT;

`ifndef NO_ASSERTIONS
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_level <= dbem_pkg::OQ_LIMIT)
    else $error("output queue overflow");

  a_queue_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_level == dbem_pkg::OQ_LIMIT) |-> in_stall)
    else $error("input not stalled with full output queue");

  a_s1_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(acc))
    else $error("stage 1 holds an item that was never transferred");
`endif

endmodule

`default_nettype wire

FILE: verif/erosion_checker.sv
// ----------------------------------------------------------------------------
// erosion_checker
// Watches the pixel, result and register ports of the erosion mask, predicts
// the keep decision of every eligible pixel and compares it with each result
// transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module erosion_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire dbem_pkg::in_pix_t               in_data,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire dbem_pkg::out_item_t             out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dbem_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [dbem_pkg::PDATA_W-1:0]    pwdata,
  input  wire logic                            pready,
  output int                                   mismatch_count,
  output int                                   pending
);
  import dbem_pkg::*;

  localparam int HALF = (WINDOW_DEF - 1) / 2;

  logic [SIZE_W-1:0]   frame_w;
  logic [SIZE_W-1:0]   frame_h;
  logic [BORDER_W-1:0] border;

  int col_run [MAX_WIDTH_DEF];
  int row_run;
  int row_pos;
  int col_pos;

  out_item_t decision_q[$];

  function automatic int clamp_dim(logic [SIZE_W-1:0] v, int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int run_inc(int v);
    return (v >= WINDOW_DEF) ? WINDOW_DEF : v + 1;
  endfunction

  // one raster step: update run counts, queue the decision for the window centre
  function automatic void erode_pixel(in_pix_t px);
    int w, h, bw, r, c, run;
    bit ok;
    out_item_t item;
    w  = clamp_dim(frame_w, MAX_WIDTH_DEF);
    h  = clamp_dim(frame_h, MAX_HEIGHT);
    bw = int'(border);
    if (px.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;

    ok = !px.depth_missing && px.depth_mm != '0 &&
         r >= bw && r + bw < h && c >= bw && c + bw < w;
    if (!ok) run = 0;
    else if (r == 0) run = 1;
    else run = run_inc(col_run[c]);
    col_run[c] = run;

    if (c == 0) row_run = 0;
    if (run >= WINDOW_DEF) row_run = run_inc(row_run);
    else row_run = 0;

    if (r >= WINDOW_DEF - 1 && c >= WINDOW_DEF - 1) begin
      item.out_row    = POS_W'(r - HALF);
      item.out_col    = POS_W'(c - HALF);
      item.keep_point = (row_run >= WINDOW_DEF);
      decision_q = {decision_q, item};
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
      border  = BORDER_WIDTH_RST;
      foreach (col_run[i]) col_run[i] = 0;
      row_run = 0;
      row_pos = 0;
      col_pos = 0;
      decision_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result row %0d col %0d keep %0b", $realtime,
                     out_data.out_row, out_data.out_col, out_data.keep_point);
          mismatch_count++;
        end else begin
          want = decision_q.pop_front();
          if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
              out_data.keep_point !== want.keep_point) begin
            if (mismatch_count < 10)
              $display("%0t: result mismatch: expected row %0d col %0d keep %0b, got row %0d col %0d keep %0b",
                       $realtime, want.out_row, want.out_col, want.keep_point,
                       out_data.out_row, out_data.out_col, out_data.keep_point);
            mismatch_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_FRAME_WIDTH:  frame_w = pwdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: frame_h = pwdata[SIZE_W-1:0];
          REG_BORDER_WIDTH: border  = pwdata[BORDER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) erode_pixel(in_data);
    end
    pending <= decision_q.size();
  end

endmodule

FILE: verif/tb_depth_border_erosion_mask.sv
// ----------------------------------------------------------------------------
// tb_depth_border_erosion_mask
// Drives depth frames through the erosion mask under a range of frame sizes
// and border bands, with random idling on both channels; the checker beside
// the block predicts and compares every keep decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_depth_border_erosion_mask;
  import dbem_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_pix_t   in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int last_w   = 640;
  int mismatch_count;
  int pending;

  depth_border_erosion_mask u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  erosion_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic in_pix_t pix(logic [15:0] d, logic m, logic s);
    in_pix_t p;
    p.depth_mm      = d;
    p.depth_missing = m;
    p.frame_start   = s;
    return p;
  endfunction

  // mostly good samples; roughly one in 'bad' is missing or zero
  function automatic in_pix_t noisy_pixel(int bad);
    in_pix_t p;
    p = pix(16'($urandom_range(1, 65535)), 1'b0, 1'b0);
    if (bad != 0 && $urandom_range(1, bad) == 1) begin
      if ($urandom_range(0, 1) == 0) p.depth_missing = 1'b1;
      else p.depth_mm = '0;
    end
    return p;
  endfunction

  // optional gap first, so valid is only ever assigned once per step
  task automatic put_pixel(in_pix_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int b);
    write_reg(REG_FRAME_WIDTH, 32'(w));
    write_reg(REG_FRAME_HEIGHT, 32'(h));
    write_reg(REG_BORDER_WIDTH, 32'(b));
  endtask

  // frame_start may mark every 'period' pixels (the first per start_first); stray marks when noisy
  task automatic run_pixels(int n, int period, int bad, bit start_first, bit noisy,
                            int hold_at);
    in_pix_t p;
    for (int i = 0; i < n; i++) begin
      p = noisy_pixel(bad);
      if (i % period == 0) p.frame_start = (i == 0) ? start_first : 1'($urandom_range(0, 1));
      else if (noisy) p.frame_start = ($urandom_range(0, 399) == 0);
      if (i == hold_at) hold_req = 1'b1;
      put_pixel(p);
    end
  endtask

  // pixels near the end may still be in flight without producing a result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result-side stalls, plus one long hold-off to back the block up
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_depth_border_erosion_mask: done, errors");
    $finish;
  end

  initial begin
    int w, h, b, n, bad, rand_items, seg_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // field extremes at the reset frame setup, row 0 only
    put_pixel(pix(16'h0000, 1'b0, 1'b1));
    put_pixel(pix(16'hFFFF, 1'b0, 1'b0));
    put_pixel(pix(16'h0001, 1'b0, 1'b0));
    put_pixel(pix(16'h8000, 1'b1, 1'b0));
    put_pixel(pix(16'h0000, 1'b1, 1'b0));
    put_pixel(pix(16'h5555, 1'b0, 1'b0));
    put_pixel(pix(16'hAAAA, 1'b1, 1'b0));
    put_pixel(pix(16'hFFFF, 1'b1, 1'b0));
    put_pixel(pix(16'h1234, 1'b0, 1'b1));
    put_pixel(pix(16'hFFFF, 1'b0, 1'b0));
    put_pixel(pix(16'h7FFF, 1'b0, 1'b0));
    put_pixel(pix(16'h0000, 1'b0, 1'b0));
    wait_idle();

    // smallest frame; upper data bits ignored; second frame by wrap only
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_F80B);
    write_reg(REG_FRAME_HEIGHT, 32'd11);
    write_reg(REG_BORDER_WIDTH, 32'd5);
    run_pixels(242, 242, 0, 1'b1, 1'b0, -1);
    wait_idle();

    // oversize width saturates to the line length, no border band
    set_frame(2047, 11, 0);
    run_pixels(24, 24, 3000, 1'b1, 1'b0, -1);
    wait_idle();

    // zero width and oversize height, band covering everything
    set_frame(0, 2047, 255);
    run_pixels(24, 24, 0, 1'b1, 1'b0, -1);
    wait_idle();

    set_frame(12, 1024, 255);
    run_pixels(144, 144, 0, 1'b1, 1'b0, -1);
    wait_idle();

    // stop at (12,12), then shrink the frame under the running position
    set_frame(20, 20, 5);
    run_pixels(252, 252, 0, 1'b1, 1'b0, -1);
    wait_idle();
    set_frame(11, 11, 5);
    run_pixels(130, 130, 40, 1'b0, 1'b0, -1);
    wait_idle();
    last_w = 11;

    // long result hold-off while pixels keep coming
    idle_on = 1'b0;
    set_frame(20, 20, 0);
    run_pixels(300, 300, 0, 1'b1, 1'b0, 220);
    wait_idle();
    last_w = 20;

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      w = $urandom_range(11, 28);
      h = $urandom_range(11, 28);
      b = $urandom_range(0, 6);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * h)
                                      : w * h * $urandom_range(1, 2);
      // no idling in the last quarter
      seg_end = (rand_items < RANDOM_ITEMS * 3 / 4) ? RANDOM_ITEMS * 3 / 4 : RANDOM_ITEMS;
      if (n > seg_end - rand_items) n = seg_end - rand_items;
      bad = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 40 : 400);
      idle_on = (rand_items < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
      set_frame(w, h, b);
      // a wider line must start a fresh frame so no stale column is read
      run_pixels(n, w * h, bad, (w > last_w) || ($urandom_range(0, 1) == 1), 1'b1, -1);
      wait_idle();
      last_w = w;
      rand_items += n;
    end

    if (mismatch_count == 0) $display("tb_depth_border_erosion_mask: done, clean");
    else $display("tb_depth_border_erosion_mask: done, errors");
    $finish;
  end

endmodule
